// ----- src/stereo_rms_level_tracker_top_defines.svh -----
// Assertion macros for the stereo RMS level tracker.
// Used by stereo_rms_level_tracker_top; expects clk and rst_n in scope.
`ifndef STEREO_RMS_LEVEL_TRACKER_TOP_DEFINES_SVH
`define STEREO_RMS_LEVEL_TRACKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent
`define SRLT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srlt same-cycle check failed");
// Check that the consequent holds in the cycle after the antecedent
`define SRLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srlt next-cycle check failed");
`else
`define SRLT_ASSERT_IMPLY(label, ante, cons)
`define SRLT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/srlt_pkg.sv -----
// Shared constants, types and arithmetic helpers for the stereo RMS level tracker.
// No dependencies; imported by the interfaces, the modules and the testbench.
package srlt_pkg;

    // Block length in sample pairs; must be a power of two
    localparam int BLOCK_LEN  = 256;
    localparam int BLOCK_LOG2 = $clog2(BLOCK_LEN);
    localparam int CNT_W      = BLOCK_LOG2;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;

    // Gain of 1.8 as 29491 / 2^14; scaled samples span -58982..58980
    localparam int                          SCALED_W   = 17;
    localparam int                          GAIN_SHIFT = 14;
    localparam int                          GAIN_PROD_W = 2 * SAMPLE_W;
    localparam logic signed [SAMPLE_W-1:0]  GAIN_NUM   = 16'sd29491;

    // Square of a scaled sample fits 32 unsigned bits
    localparam int SQ_W     = 32;
    localparam int SQ_PROD_W = 2 * SCALED_W;
    localparam int SUM_W    = SQ_W + 1 + BLOCK_LOG2;
    localparam int MEAN_W   = SUM_W - BLOCK_LOG2 - 1;

    // Square root unit
    localparam int ROOT_W = MEAN_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int STEP_W = $clog2(ROOT_W);

    // Smoothing weights (0.93 and 0.07 in Q0.16, summing to 65536)
    localparam int                  PROD_W     = 2 * LEVEL_W;
    localparam logic [LEVEL_W-1:0]  SMOOTH_OLD = 16'd60948;
    localparam logic [LEVEL_W-1:0]  SMOOTH_NEW = 16'd4588;

    // Reset values
    localparam logic [LEVEL_W-1:0] MIN_THR_RESET = 16'd328;
    localparam logic [LEVEL_W-1:0] DECAY_RESET   = 16'd6554;
    localparam logic [LEVEL_W-1:0] THR_RESET     = 16'd328;

    // Configuration register map
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_THRESHOLD = CFG_IDX_W'(0),
        REG_DECAY_RATE    = CFG_IDX_W'(1)
    } cfg_reg_t;

    // Queue between front and back end
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQRT,
        BK_MUL1,
        BK_MUL2,
        BK_UPDATE
    } back_state_t;

    // Scale a sample by the gain, rounding toward minus infinity
    function automatic logic signed [SCALED_W-1:0] apply_gain(
        input logic signed [SAMPLE_W-1:0] s
    );
        logic signed [GAIN_PROD_W-1:0] p;
        p = s * GAIN_NUM;
        return p[SCALED_W+GAIN_SHIFT-1:GAIN_SHIFT];
    endfunction

    // Square of a scaled sample, always non-negative
    function automatic logic [SQ_W-1:0] square(
        input logic signed [SCALED_W-1:0] x
    );
        logic signed [SQ_PROD_W-1:0] p;
        p = x * x;
        return p[SQ_W-1:0];
    endfunction

endpackage

// ----- src/srlt_if.sv -----
// Handshake channel interfaces: sample pairs in, level results out, register writes.
// Depends on srlt_pkg for field widths.
interface srlt_in_if import srlt_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface srlt_out_if import srlt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] rms_level;
    logic [LEVEL_W-1:0] smoothed_level;
    logic [LEVEL_W-1:0] peak_threshold;
    logic [LEVEL_W-1:0] block_count;

    modport source (output valid, output rms_level, output smoothed_level,
                    output peak_threshold, output block_count, input ready);
    modport sink   (input valid, input rms_level, input smoothed_level,
                    input peak_threshold, input block_count, output ready);
endinterface

interface srlt_cfg_if import srlt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [LEVEL_W-1:0]   wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- src/srlt_front.sv -----
// Front end: accepts sample pairs, scales, squares and accumulates them per block.
// Depends on srlt_pkg and srlt_in_if; pushes each block mean into the queue.
module srlt_front import srlt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    srlt_in_if.sink           samples,
    input  q_status_t         q_status,
    output logic              push,
    output logic [MEAN_W-1:0] push_mean
);

    logic                       sc_valid_reg;
    logic                       sc_last_reg;
    logic signed [SCALED_W-1:0] sc_l_reg;
    logic signed [SCALED_W-1:0] sc_r_reg;
    logic                       sq_valid_reg;
    logic                       sq_last_reg;
    logic [SQ_W-1:0]            sq_l_reg;
    logic [SQ_W-1:0]            sq_r_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [SUM_W-1:0]           acc_reg;
    logic [SUM_W-1:0]           acc_sum;
    logic                       stall;
    logic                       en;
    logic                       accept;

    // Hold the whole pipe when a block end meets a full queue
    assign stall         = sq_valid_reg && sq_last_reg && q_status.full;
    assign en            = !stall;
    assign samples.ready = en;
    assign accept        = samples.valid && en;

    // Add both squares to the running sum
    assign acc_sum   = acc_reg + SUM_W'(sq_l_reg) + SUM_W'(sq_r_reg);
    assign push      = sq_valid_reg && sq_last_reg && en;
    assign push_mean = acc_sum[SUM_W-1:BLOCK_LOG2+1];

    // Advance valid flags, pair count and accumulator
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sc_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            acc_reg      <= '0;
        end else if (en) begin
            sc_valid_reg <= samples.valid;
            sq_valid_reg <= sc_valid_reg;
            if (accept) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (sq_valid_reg) begin
                acc_reg <= sq_last_reg ? '0 : acc_sum;
            end
        end
    end

    // Scale, then square
    always_ff @(posedge clk) begin
        if (en) begin
            sc_last_reg <= (cnt_reg == CNT_W'(BLOCK_LEN - 1));
            sc_l_reg    <= apply_gain(samples.left_sample);
            sc_r_reg    <= apply_gain(samples.right_sample);
            sq_last_reg <= sc_last_reg;
            sq_l_reg    <= square(sc_l_reg);
            sq_r_reg    <= square(sc_r_reg);
        end
    end

endmodule

// ----- src/srlt_queue.sv -----
// Two-entry queue of block means between the front end and the back end.
// Depends on srlt_pkg.
module srlt_queue import srlt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [MEAN_W-1:0] push_data,
    input  logic              pop,
    output logic [MEAN_W-1:0] pop_data,
    output q_status_t         status
);

    logic [MEAN_W-1:0]  mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/srlt_back.sv -----
// Back end: square root of the block mean, smoothing, threshold decay and result register.
// Depends on srlt_pkg and srlt_out_if; pops block means from the queue.
module srlt_back import srlt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  q_status_t          q_status,
    input  logic [MEAN_W-1:0]  q_data,
    output logic               pop,
    input  logic [LEVEL_W-1:0] min_threshold,
    input  logic [LEVEL_W-1:0] decay_rate,
    srlt_out_if.source         results
);

    back_state_t        state_reg, state_next;
    logic [MEAN_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [PROD_W-1:0]  p_old_reg, p_old_next;
    logic [PROD_W-1:0]  p_new_reg, p_new_next;
    logic [LEVEL_W-1:0] gap_reg, gap_next;
    logic               below_reg, below_next;
    logic [LEVEL_W-1:0] dstep_reg, dstep_next;
    logic [LEVEL_W-1:0] smooth_reg, smooth_next;
    logic [LEVEL_W-1:0] thr_reg, thr_next;
    logic [LEVEL_W-1:0] blocks_reg, blocks_next;
    logic [LEVEL_W-1:0] rms_out_reg, rms_out_next;
    logic               out_valid_reg, out_valid_next;

    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               fits;
    logic [REM_W+1:0]   rem_diff;
    logic [PROD_W-1:0]  gap_prod;
    logic [PROD_W:0]    smooth_sum;
    logic [LEVEL_W-1:0] thr_decayed;
    logic [LEVEL_W-1:0] thr_new;

    // One digit of the restoring square root per cycle
    assign rem_sh   = {rem_reg, rad_reg[MEAN_W-1 -: 2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign fits     = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;

    // Threshold decay and smoothing arithmetic
    assign gap_prod    = gap_reg * decay_rate;
    assign smooth_sum  = {1'b0, p_old_reg} + {1'b0, p_new_reg};
    assign thr_decayed = below_reg ? thr_reg + dstep_reg : thr_reg - dstep_reg;
    assign thr_new     = (root_reg > thr_decayed) ? root_reg : thr_decayed;

    // Root is at most 16 bits, so the level never needs clamping
    assign results.valid          = out_valid_reg;
    assign results.rms_level      = rms_out_reg;
    assign results.smoothed_level = smooth_reg;
    assign results.peak_threshold = thr_reg;
    assign results.block_count    = blocks_reg;

    // Sequence one block through root, products and update
    always_comb begin
        state_next     = state_reg;
        pop            = 1'b0;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        p_old_next     = p_old_reg;
        p_new_next     = p_new_reg;
        gap_next       = gap_reg;
        below_next     = below_reg;
        dstep_next     = dstep_reg;
        smooth_next    = smooth_reg;
        thr_next       = thr_reg;
        blocks_next    = blocks_reg;
        rms_out_next   = rms_out_reg;
        out_valid_next = out_valid_reg && !results.ready;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    rad_next   = q_data;
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = BK_SQRT;
                end
            end
            BK_SQRT: begin
                rad_next  = {rad_reg[MEAN_W-3:0], 2'b00};
                rem_next  = fits ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], fits};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    state_next = BK_MUL1;
                end
            end
            BK_MUL1: begin
                p_old_next = smooth_reg * SMOOTH_OLD;
                below_next = (thr_reg < min_threshold);
                gap_next   = (thr_reg < min_threshold) ? min_threshold - thr_reg
                                                        : thr_reg - min_threshold;
                state_next = BK_MUL2;
            end
            BK_MUL2: begin
                p_new_next = root_reg * SMOOTH_NEW;
                dstep_next = gap_prod[PROD_W-1:LEVEL_W];
                state_next = BK_UPDATE;
            end
            BK_UPDATE: begin
                // Wait for the result register to drain
                if (!out_valid_reg || results.ready) begin
                    smooth_next    = smooth_sum[PROD_W-1:LEVEL_W];
                    thr_next       = thr_new;
                    blocks_next    = blocks_reg + LEVEL_W'(1);
                    rms_out_next   = root_reg;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control and level state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            smooth_reg    <= '0;
            thr_reg       <= THR_RESET;
            blocks_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            smooth_reg    <= smooth_next;
            thr_reg       <= thr_next;
            blocks_reg    <= blocks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk) begin
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        p_old_reg   <= p_old_next;
        p_new_reg   <= p_new_next;
        gap_reg     <= gap_next;
        below_reg   <= below_next;
        dstep_reg   <= dstep_next;
        rms_out_reg <= rms_out_next;
    end

endmodule

// ----- src/stereo_rms_level_tracker_top.sv -----
// Stereo RMS level tracker: one sample pair accepted per clock while the queue has room.
// From the last pair of a block to result valid: the front scale and square stages, the queue,
// the 16-step square root, two multiply steps and the update.
// The back end finishes a block well before a 256-pair block can arrive; the input stalls
// only when results are held off and the two-entry queue fills. Reset clears counts, sums,
// smoothed level and block count, and loads threshold and registers with 328 and 6554.
`include "stereo_rms_level_tracker_top_defines.svh"
module stereo_rms_level_tracker_top import srlt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    srlt_in_if.sink     samples,
    srlt_out_if.source  results,
    srlt_cfg_if.sink    cfg
);

    logic [LEVEL_W-1:0] min_thr_reg;
    logic [LEVEL_W-1:0] decay_reg;
    logic               q_push;
    logic               q_pop;
    logic [MEAN_W-1:0]  push_mean;
    logic [MEAN_W-1:0]  q_data;
    q_status_t          q_status;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    // Decode register writes; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_thr_reg <= MIN_THR_RESET;
            decay_reg   <= DECAY_RESET;
        end else if (cfg.valid) begin
            unique case (cfg.reg_index)
                REG_MIN_THRESHOLD: min_thr_reg <= cfg.wdata;
                REG_DECAY_RATE:    decay_reg   <= cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    srlt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .q_status  (q_status),
        .push      (q_push),
        .push_mean (push_mean)
    );

    srlt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_mean),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    srlt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_data        (q_data),
        .pop           (q_pop),
        .min_threshold (min_thr_reg),
        .decay_rate    (decay_reg),
        .results       (results)
    );

    // Queue and stall consistency
    `SRLT_ASSERT_IMPLY(a_no_overflow, q_push, !q_status.full)
    `SRLT_ASSERT_IMPLY(a_pop_nonempty, q_pop, !q_status.empty)
    `SRLT_ASSERT_IMPLY(a_stall_on_full, !samples.ready, q_status.full)
    `SRLT_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_status.empty)

endmodule

// ----- tb/tb_stereo_rms_level_tracker_top.sv -----
// Self-checking testbench for stereo_rms_level_tracker_top: random sample blocks,
// register sweeps and back-pressure, checked against a built-in level predictor.
// Depends on srlt_pkg and the srlt_in_if, srlt_out_if and srlt_cfg_if interfaces.
module tb_stereo_rms_level_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srlt_pkg::*;

    localparam int     CLK_HALF_NS     = 5;
    localparam int     RESET_CYCLES    = 6;
    localparam int     SETTLE_CYCLES   = 40;
    localparam int     HOLD_OFF_CYCLES = 2000;
    localparam longint RUN_LIMIT_NS    = 15_000_000;

    // Arithmetic of the level tracker
    localparam longint GAIN_Q14         = 29491;
    localparam int     GAIN_FRAC_BITS   = 14;
    localparam longint OLD_WEIGHT       = 60948;
    localparam longint NEW_WEIGHT       = 4588;
    localparam int     WEIGHT_FRAC_BITS = 16;
    localparam int     DECAY_FRAC_BITS  = 16;
    localparam longint LEVEL_MAX        = 65535;

    localparam logic [LEVEL_W-1:0] FLOOR_DEFAULT = 16'd328;
    localparam logic [LEVEL_W-1:0] DECAY_DEFAULT = 16'd6554;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] FIRST_UNMAPPED_REG = 4'd2;
    localparam logic [CFG_IDX_W-1:0] LAST_REG_INDEX     = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] smoothed;
        logic [LEVEL_W-1:0] threshold;
        logic [LEVEL_W-1:0] count;
    } level_result_t;

    typedef enum int {
        STYLE_SILENT,
        STYLE_QUIET,
        STYLE_LOUD,
        STYLE_FULL_SCALE,
        STYLE_PEAK,
        STYLE_MIXED
    } block_style_t;

    logic clk = 1'b0;
    logic rst_n;

    srlt_in_if  samples_ch ();
    srlt_out_if results_ch ();
    srlt_cfg_if cfg_ch ();

    stereo_rms_level_tracker_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // Predictor state
    longint unsigned    sq_accum;
    int                 pairs_in_block;
    logic [LEVEL_W-1:0] smooth_lvl;
    logic [LEVEL_W-1:0] peak_thr;
    logic [LEVEL_W-1:0] blocks_total;
    logic [LEVEL_W-1:0] floor_reg;
    logic [LEVEL_W-1:0] decay_reg;

    level_result_t pending_levels[$];

    int error_count        = 0;
    int results_checked    = 0;
    int pairs_sent         = 0;
    int reg_writes         = 0;
    int input_stall_cycles = 0;
    int hold_request       = 0;
    bit burst_mode         = 1'b0;
    bit block_burst        = 1'b0;

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // Gain of 1.8 in Q14, floor rounding
    function automatic longint scale_sample(input logic signed [SAMPLE_W-1:0] s);
        longint prod;
        prod = longint'(s) * GAIN_Q14;
        return prod >>> GAIN_FRAC_BITS;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Accumulate one pair; close the block and queue its levels on the last pair
    task automatic predict_pair(input logic signed [SAMPLE_W-1:0] l,
                                input logic signed [SAMPLE_W-1:0] r);
        longint          sl;
        longint          sr;
        longint unsigned root;
        longint unsigned gap;
        longint unsigned decay_step;
        logic [LEVEL_W-1:0] rms;
        logic [LEVEL_W-1:0] thr;
        sl = scale_sample(l);
        sr = scale_sample(r);
        sq_accum += longint'(sl * sl) + longint'(sr * sr);
        pairs_in_block++;
        if (pairs_in_block < BLOCK_LEN)
            return;

        root = int_sqrt(sq_accum / longint'(2 * BLOCK_LEN));
        rms = (root > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(root);
        sq_accum = 0;
        pairs_in_block = 0;

        smooth_lvl = LEVEL_W'((longint'(smooth_lvl) * OLD_WEIGHT
                               + longint'(rms) * NEW_WEIGHT) >> WEIGHT_FRAC_BITS);

        // Decay toward the floor from either side, then capture a new peak
        if (peak_thr >= floor_reg)
        begin
            gap = longint'(peak_thr) - longint'(floor_reg);
            decay_step = (gap * longint'(decay_reg)) >> DECAY_FRAC_BITS;
            thr = peak_thr - LEVEL_W'(decay_step);
        end
        else
        begin
            gap = longint'(floor_reg) - longint'(peak_thr);
            decay_step = (gap * longint'(decay_reg)) >> DECAY_FRAC_BITS;
            thr = peak_thr + LEVEL_W'(decay_step);
        end
        if (rms > thr)
            thr = rms;
        peak_thr = thr;
        blocks_total = blocks_total + 1'b1;

        pending_levels.insert(pending_levels.size(),
                              level_result_t'({rms, smooth_lvl, peak_thr, blocks_total}));
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic check_level_result(input level_result_t got);
        level_result_t want;
        if (pending_levels.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: rms %0d, block %0d",
                                      got.rms, got.count));
            return;
        end
        want = pending_levels.pop_front();
        results_checked++;
        if (got.rms !== want.rms)
            report_mismatch($sformatf("block %0d rms_level: expected %0d, got %0d",
                                      want.count, want.rms, got.rms));
        if (got.smoothed !== want.smoothed)
            report_mismatch($sformatf("block %0d smoothed_level: expected %0d, got %0d",
                                      want.count, want.smoothed, got.smoothed));
        if (got.threshold !== want.threshold)
            report_mismatch($sformatf("block %0d peak_threshold: expected %0d, got %0d",
                                      want.count, want.threshold, got.threshold));
        if (got.count !== want.count)
            report_mismatch($sformatf("block_count: expected %0d, got %0d",
                                      want.count, got.count));
    endtask

    // Check every accepted result and count input stall cycles
    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
            check_level_result(level_result_t'({results_ch.rms_level,
                                                results_ch.smoothed_level,
                                                results_ch.peak_threshold,
                                                results_ch.block_count}));
        if (rst_n && samples_ch.valid && !samples_ch.ready)
            input_stall_cycles++;
    end

    // Toggle result ready with random gaps; serve a requested hold-off in cycles
    initial
    begin : result_ready_driver
        int low_cycles;
        int high_cycles;
        results_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            low_cycles = pick_gap() + hold_request;
            hold_request = 0;
            if (low_cycles > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (low_cycles) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            high_cycles = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 8);
            repeat (high_cycles) @(posedge clk);
        end
    end

    // Offer one pair and hold it until the transaction completes
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
        int gap_cycles;
        gap_cycles = (burst_mode || block_burst) ? 0 : pick_gap();
        if (gap_cycles > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        samples_ch.valid        <= 1'b1;
        samples_ch.left_sample  <= l;
        samples_ch.right_sample <= r;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        predict_pair(l, r);
        pairs_sent++;
    endtask

    task automatic pause_sender();
        samples_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_results_drained();
        while (pending_levels.size() != 0)
            @(posedge clk);
    endtask

    // Drop valid, wait for every result, then let the back end go quiet
    task automatic settle_idle();
        pause_sender();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [LEVEL_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_MIN_THRESHOLD: floor_reg = value;
            REG_DECAY_RATE:    decay_reg = value;
            default: ;
        endcase
        reg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input block_style_t st,
                                                               input int amp);
        case (st)
            STYLE_SILENT:     return SAMPLE_W'(int'($urandom_range(0, 2)) - 1);
            STYLE_QUIET:      return SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
            STYLE_FULL_SCALE: return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            STYLE_PEAK:       return SAMPLE_MIN;
            default:          return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic block_style_t random_style();
        return block_style_t'($urandom_range(STYLE_SILENT, STYLE_MIXED));
    endfunction

    // Send one whole block; mixed blocks pick the style per pair
    task automatic send_block(input block_style_t style);
        int amp;
        block_style_t st;
        amp = $urandom_range(16, 4096);
        block_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < BLOCK_LEN; i++)
        begin
            st = style;
            if (style == STYLE_MIXED)
                st = block_style_t'($urandom_range(STYLE_QUIET, STYLE_FULL_SCALE));
            send_pair(pick_sample(st, amp), pick_sample(st, amp));
        end
        block_burst = 1'b0;
    endtask

    task automatic run_setting(input logic [LEVEL_W-1:0] floor_val,
                               input logic [LEVEL_W-1:0] decay_val,
                               input int blocks);
        settle_idle();
        write_register(REG_MIN_THRESHOLD, floor_val);
        write_register(REG_DECAY_RATE, decay_val);
        repeat (blocks) send_block(random_style());
    endtask

    // Field extremes at reset settings, then a peak block and two silent ones to decay
    task automatic test_edge_samples();
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(16'sd0, 16'sd0);
        send_pair(-16'sd1, 16'sd1);
        send_pair(16'sd1, -16'sd1);
        send_pair(-16'sd1, -16'sd1);
        send_pair(16'sh4000, -16'sh4000);
        send_pair(16'sh5555, 16'shAAAA);
        send_pair(16'shAAAA, 16'sh5555);
        send_pair(16'sh0001, SAMPLE_MIN);
        while (pairs_in_block != 0)
            send_pair(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
        send_block(STYLE_PEAK);
        send_block(STYLE_SILENT);
        send_block(STYLE_SILENT);
    endtask

    task automatic test_pattern_blocks();
        repeat (10) send_block(random_style());
    endtask

    // Register extremes: floor below and above the threshold, no decay and full decay, then random and defaults
    task automatic test_register_sweep();
        run_setting('0, '0, 3);
        run_setting(LEVEL_W'(LEVEL_MAX), LEVEL_W'(LEVEL_MAX), 3);
        run_setting('0, LEVEL_W'(LEVEL_MAX), 3);
        run_setting(LEVEL_W'(LEVEL_MAX), '0, 3);
        run_setting(LEVEL_W'($urandom()), LEVEL_W'($urandom()), 3);
        run_setting(LEVEL_W'($urandom_range(0, 4000)), LEVEL_W'($urandom()), 3);
        run_setting(FLOOR_DEFAULT, DECAY_DEFAULT, 3);
    endtask

    // Writes to unmapped indexes must leave both registers untouched
    task automatic test_unmapped_register();
        settle_idle();
        write_register(CFG_IDX_W'($urandom_range(FIRST_UNMAPPED_REG, LAST_REG_INDEX)),
                       LEVEL_W'($urandom()));
        write_register(LAST_REG_INDEX, '0);
        write_register(FIRST_UNMAPPED_REG, LEVEL_W'(LEVEL_MAX));
        repeat (2) send_block(random_style());
    endtask

    // Stop offering pairs until every pending result has arrived, between blocks
    task automatic test_sender_pause();
        for (int i = 0; i < 4; i++)
        begin
            send_block(random_style());
            pause_sender();
            wait_results_drained();
        end
    endtask

    // Hold results off for a long stretch while pairs stream in back to back
    task automatic test_backpressure();
        hold_request = HOLD_OFF_CYCLES;
        burst_mode = 1'b1;
        repeat (6) send_block(STYLE_MIXED);
        burst_mode = 1'b0;
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        samples_ch.valid        = 1'b0;
        samples_ch.left_sample  = '0;
        samples_ch.right_sample = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.reg_index        = REG_MIN_THRESHOLD;
        cfg_ch.wdata            = '0;

        sq_accum       = 0;
        pairs_in_block = 0;
        smooth_lvl     = '0;
        peak_thr       = FLOOR_DEFAULT;
        blocks_total   = '0;
        floor_reg      = FLOOR_DEFAULT;
        decay_reg      = DECAY_DEFAULT;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_samples();
        test_pattern_blocks();
        test_register_sweep();
        test_unmapped_register();
        test_sender_pause();
        test_backpressure();

        pause_sender();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d sample pairs in %0d blocks and %0d register writes,",
                 pairs_sent, blocks_total, reg_writes);
        $display("%0d results checked; input stalled %0d cycles under result hold-off.",
                 results_checked, input_stall_cycles);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Bound the run in case the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("ERROR: run limit reached with %0d results pending", pending_levels.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
